>>> hw/rtl/thadc_pkg.sv
package thadc_pkg;

    localparam int RAW_W       = 10;
    localparam int X_W         = 19;
    localparam int CV_W        = 9;
    localparam int IDX_W       = 7;
    localparam int START_W     = 8;
    localparam int LEN_W       = 3;
    localparam int BASE_W      = 7;
    localparam int NUM_W       = 23;
    localparam int DEN_W       = 13;
    localparam int RECIP_W     = 11;
    localparam int RECIP_SHIFT = 22;
    localparam int QE_W        = 11;
    localparam int PROD_W      = 24;
    localparam int CODE_W      = 8;

    localparam int FullScale = 1023;

    localparam logic [CV_W-1:0]   CV_TABLE_LO = 9'd148;
    localparam logic [CV_W-1:0]   IDX_LAST    = 9'd69;
    localparam logic [CODE_W-1:0] CODE_MAX    = 8'd255;
    localparam logic [CODE_W-1:0] FAULT_THRESHOLD_RESET = 8'd220;

    // floor(2^22 / (1023 * length)) for each segment length
    localparam logic [RECIP_W-1:0] RECIP_LEN3 = RECIP_W'((1 << RECIP_SHIFT) / (FullScale * 3));
    localparam logic [RECIP_W-1:0] RECIP_LEN4 = RECIP_W'((1 << RECIP_SHIFT) / (FullScale * 4));
    localparam logic [RECIP_W-1:0] RECIP_LEN5 = RECIP_W'((1 << RECIP_SHIFT) / (FullScale * 5));
    localparam logic [RECIP_W-1:0] RECIP_LEN6 = RECIP_W'((1 << RECIP_SHIFT) / (FullScale * 6));

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic [BASE_W-1:0]  base;
    } seg_entry_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        seg_entry_t     seg;
    } seg_info_t;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-2:0] num;
        logic [DEN_W-1:0] den;
        logic [QE_W-1:0]  qe;
    } quot_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              over;
    } result_t;

    function automatic seg_entry_t seg_lookup(input logic [IDX_W-1:0] idx);
        seg_entry_t e;
        if (idx <= 7'd2)       e = '{8'd148, 3'd3, 7'd65};
        else if (idx <= 7'd6)  e = '{8'd151, 3'd4, 7'd60};
        else if (idx <= 7'd10) e = '{8'd155, 3'd4, 7'd55};
        else if (idx <= 7'd14) e = '{8'd159, 3'd4, 7'd50};
        else if (idx <= 7'd19) e = '{8'd163, 3'd5, 7'd45};
        else if (idx <= 7'd25) e = '{8'd168, 3'd6, 7'd40};
        else if (idx <= 7'd31) e = '{8'd174, 3'd6, 7'd35};
        else if (idx <= 7'd37) e = '{8'd180, 3'd6, 7'd30};
        else if (idx <= 7'd43) e = '{8'd186, 3'd6, 7'd25};
        else if (idx <= 7'd50) e = '{8'd192, 3'd6, 7'd20};
        else if (idx <= 7'd56) e = '{8'd199, 3'd6, 7'd15};
        else if (idx <= 7'd62) e = '{8'd205, 3'd6, 7'd10};
        else if (idx <= 7'd68) e = '{8'd211, 3'd6, 7'd5};
        else                   e = '{8'd217, 3'd6, 7'd0};
        return e;
    endfunction

    function automatic logic [RECIP_W-1:0] recip_of_len(input logic [LEN_W-1:0] len);
        logic [RECIP_W-1:0] r;
        case (len)
            3'd3:    r = RECIP_LEN3;
            3'd4:    r = RECIP_LEN4;
            3'd5:    r = RECIP_LEN5;
            default: r = RECIP_LEN6;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/thadc_front.sv
module thadc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [7:0]            first_byte,
    input  logic [7:0]            second_byte,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output thadc_pkg::seg_info_t  dn_data
);

    logic                        s1_valid_reg;
    logic [thadc_pkg::X_W-1:0]   s1_x_reg;
    logic [thadc_pkg::X_W-1:0]   s1_x_next;
    logic                        s2_valid_reg;
    thadc_pkg::seg_info_t        s2_data_reg;
    thadc_pkg::seg_info_t        s2_data_next;
    logic                        s1_ready;
    logic                        s2_ready;

    logic [thadc_pkg::RAW_W-1:0] raw;
    logic [thadc_pkg::X_W-1:0]   raw_x;
    logic [thadc_pkg::CV_W-1:0]  q0;
    logic [thadc_pkg::X_W-1:0]   rem;
    logic [thadc_pkg::CV_W-1:0]  cv;
    logic [thadc_pkg::CV_W-1:0]  off;
    logic [thadc_pkg::IDX_W-1:0] idx;

    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;
    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_data_reg;

    // stage 1: reading and raw * 330 by shifts
    always_comb
    begin
        raw       = {first_byte[6:0], second_byte[7:5]};
        raw_x     = thadc_pkg::X_W'(raw);
        s1_x_next = (raw_x << 8) + (raw_x << 6) + (raw_x << 3) + (raw_x << 1);
    end

    // stage 2: floor(x / 1023) as x >> 10 plus one correction, then segment lookup
    always_comb
    begin
        q0  = s1_x_reg[thadc_pkg::X_W-1:10];
        rem = s1_x_reg - ((thadc_pkg::X_W'(q0) << 10) - thadc_pkg::X_W'(q0));
        cv  = q0 + thadc_pkg::CV_W'(rem >= thadc_pkg::X_W'(thadc_pkg::FullScale));
        off = cv - thadc_pkg::CV_TABLE_LO;
        if (cv < thadc_pkg::CV_TABLE_LO)
        begin
            idx = '0;
        end
        else if (off > thadc_pkg::IDX_LAST)
        begin
            idx = thadc_pkg::IDX_LAST[thadc_pkg::IDX_W-1:0];
        end
        else
        begin
            idx = off[thadc_pkg::IDX_W-1:0];
        end
        s2_data_next.x   = s1_x_reg;
        s2_data_next.seg = thadc_pkg::seg_lookup(idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            s1_x_reg <= s1_x_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

endmodule

>>> hw/rtl/thadc_interp.sv
module thadc_interp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  thadc_pkg::seg_info_t  up_data,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output thadc_pkg::quot_t      dn_data
);

    logic                           s3_valid_reg;
    logic [thadc_pkg::NUM_W-1:0]    s3_num_reg;
    logic [thadc_pkg::NUM_W-1:0]    s3_num_next;
    logic [thadc_pkg::DEN_W-1:0]    s3_den_reg;
    logic [thadc_pkg::DEN_W-1:0]    s3_den_next;
    logic [thadc_pkg::RECIP_W-1:0]  s3_recip_reg;
    logic [thadc_pkg::RECIP_W-1:0]  s3_recip_next;
    logic                           s4_valid_reg;
    thadc_pkg::quot_t               s4_data_reg;
    thadc_pkg::quot_t               s4_data_next;
    logic                           s3_ready;
    logic                           s4_ready;

    logic [9:0]                     base_len;
    logic signed [24:0]             base_term;
    logic signed [24:0]             start_term;
    logic signed [24:0]             diff;
    logic signed [24:0]             num_wide;
    logic [thadc_pkg::NUM_W+thadc_pkg::RECIP_W-2:0] prod;

    assign s4_ready = !s4_valid_reg || dn_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign up_ready = s3_ready;
    assign dn_valid = s4_valid_reg;
    assign dn_data  = s4_data_reg;

    // stage 3: N = 4*base*1023*len - 20*(x - 1023*start), D = 1023*len
    always_comb
    begin
        base_len   = 10'(up_data.seg.base) * 10'(up_data.seg.len);
        base_term  = $signed((25'(base_len) << 12) - (25'(base_len) << 2));
        start_term = $signed((25'(up_data.seg.start) << 10) - 25'(up_data.seg.start));
        diff       = $signed(25'(up_data.x)) - start_term;
        num_wide   = base_term - ((diff <<< 4) + (diff <<< 2));
        s3_num_next   = num_wide[thadc_pkg::NUM_W-1:0];
        s3_den_next   = (thadc_pkg::DEN_W'(up_data.seg.len) << 10)
                        - thadc_pkg::DEN_W'(up_data.seg.len);
        s3_recip_next = thadc_pkg::recip_of_len(up_data.seg.len);
    end

    // stage 4: quotient estimate N * floor(2^22 / D) >> 22, low by at most one
    always_comb
    begin
        prod = (thadc_pkg::NUM_W + thadc_pkg::RECIP_W - 1)'(s3_num_reg[thadc_pkg::NUM_W-2:0])
             * (thadc_pkg::NUM_W + thadc_pkg::RECIP_W - 1)'(s3_recip_reg);
        s4_data_next.neg = s3_num_reg[thadc_pkg::NUM_W-1];
        s4_data_next.num = s3_num_reg[thadc_pkg::NUM_W-2:0];
        s4_data_next.den = s3_den_reg;
        s4_data_next.qe  = prod[thadc_pkg::NUM_W+thadc_pkg::RECIP_W-2:thadc_pkg::RECIP_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= up_valid;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && up_valid)
        begin
            s3_num_reg   <= s3_num_next;
            s3_den_reg   <= s3_den_next;
            s3_recip_reg <= s3_recip_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_data_reg <= s4_data_next;
        end
    end

endmodule

>>> hw/rtl/thadc_quot.sv
module thadc_quot (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  thadc_pkg::quot_t              up_data,
    input  logic [thadc_pkg::CODE_W-1:0]  threshold,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output thadc_pkg::result_t            dn_data
);

    logic                            s5_valid_reg;
    thadc_pkg::quot_t                s5_quot_reg;
    logic [thadc_pkg::PROD_W-1:0]    s5_prod_reg;
    logic [thadc_pkg::PROD_W-1:0]    s5_prod_next;
    logic                            s6_valid_reg;
    thadc_pkg::result_t              s6_data_reg;
    thadc_pkg::result_t              s6_data_next;
    logic                            s5_ready;
    logic                            s6_ready;

    logic [thadc_pkg::PROD_W-1:0]    rem;
    logic                            bump;
    logic [thadc_pkg::QE_W:0]        quo;

    assign s6_ready = !s6_valid_reg || dn_ready;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign up_ready = s5_ready;
    assign dn_valid = s6_valid_reg;
    assign dn_data  = s6_data_reg;

    // stage 5: back-multiply the estimate
    assign s5_prod_next = thadc_pkg::PROD_W'(up_data.qe) * thadc_pkg::PROD_W'(up_data.den);

    // stage 6: one correction step, clamp, threshold compare
    always_comb
    begin
        rem  = thadc_pkg::PROD_W'(s5_quot_reg.num) - s5_prod_reg;
        bump = rem >= thadc_pkg::PROD_W'(s5_quot_reg.den);
        quo  = (thadc_pkg::QE_W + 1)'(s5_quot_reg.qe) + (thadc_pkg::QE_W + 1)'(bump);
        if (s5_quot_reg.neg)
        begin
            s6_data_next.code = '0;
        end
        else if (quo > (thadc_pkg::QE_W + 1)'(thadc_pkg::CODE_MAX))
        begin
            s6_data_next.code = thadc_pkg::CODE_MAX;
        end
        else
        begin
            s6_data_next.code = quo[thadc_pkg::CODE_W-1:0];
        end
        s6_data_next.over = s6_data_next.code >= threshold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (s5_ready)
            begin
                s5_valid_reg <= up_valid;
            end
            if (s6_ready)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready && up_valid)
        begin
            s5_quot_reg <= up_data;
            s5_prod_reg <= s5_prod_next;
        end
        if (s6_ready && s5_valid_reg)
        begin
            s6_data_reg <= s6_data_next;
        end
    end

endmodule

>>> hw/rtl/thermistor_adc_to_temperature.sv
// thermistor reading to temperature code
//
// input channel: in_valid / in_stall with first_byte and second_byte, the two
// bytes of one 10-bit converter sample. a transaction completes on a clock edge
// with in_valid high and in_stall low.
// output channel: out_valid / out_stall with temperature_code (0.25 degree
// steps, 0..255) and over_limit. the receiver holds out_stall high to pause.
// config channel: cfg_valid / cfg_ready with cfg_data, the fault threshold;
// cfg_ready is always high. write it only while the pipeline is empty.
//
// six register stages: reading scale, segment lookup, interpolation terms,
// reciprocal multiply, back-multiply, correction and clamp. one sample per
// cycle is taken and one result per cycle is delivered while out_stall is low.
// when out_stall is high a full pipeline holds every stage and raises
// in_stall; empty stages still fill, so bubbles are squeezed out.
// reset empties the pipeline and sets the threshold to 220.
module thermistor_adc_to_temperature (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] first_byte,
    input  logic [7:0] second_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] temperature_code,
    output logic       over_limit,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [thadc_pkg::CODE_W-1:0] threshold_reg;

    logic                  front_ready;
    logic                  seg_valid;
    logic                  seg_ready;
    thadc_pkg::seg_info_t  seg_data;
    logic                  quot_valid;
    logic                  quot_ready;
    thadc_pkg::quot_t      quot_data;
    thadc_pkg::result_t    result;

    assign cfg_ready = 1'b1;
    assign in_stall  = !front_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= thadc_pkg::FAULT_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    thadc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (in_valid),
        .up_ready    (front_ready),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .dn_valid    (seg_valid),
        .dn_ready    (seg_ready),
        .dn_data     (seg_data)
    );

    thadc_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (seg_valid),
        .up_ready (seg_ready),
        .up_data  (seg_data),
        .dn_valid (quot_valid),
        .dn_ready (quot_ready),
        .dn_data  (quot_data)
    );

    thadc_quot u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (quot_valid),
        .up_ready  (quot_ready),
        .up_data   (quot_data),
        .threshold (threshold_reg),
        .dn_valid  (out_valid),
        .dn_ready  (!out_stall),
        .dn_data   (result)
    );

    assign temperature_code = result.code;
    assign over_limit       = result.over;

endmodule

>>> hw/rtl/thadc_checker.sv
module thadc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] temperature_code,
    input logic       over_limit
);

    // a stalled result stays offered
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(temperature_code) && $stable(over_limit))
        else $error("result changed while stalled");

    // backpressure only reaches the input when the output is full and stalled
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in the pipeline");

    // an accepted transaction reaches out_valid while out_stall stays low
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("accepted transaction did not reach the output");

endmodule

bind thermistor_adc_to_temperature thadc_checker u_checker (.*);
